// ===== src/chrr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrr_pkg: shared types and constants of the hash ring router
// ring geometry, opcode and status codes, sequencer states
// ----------------------------------------------------------------------------
package chrr_pkg;

    localparam int RING_SLOTS = 64;
    localparam int IDX_W      = $clog2(RING_SLOTS);
    localparam int CNT_W      = $clog2(RING_SLOTS + 1);
    localparam int HASH_W     = 32;
    localparam int SID_W      = 16;
    localparam int ENTRY_W    = HASH_W + SID_W;

    localparam int IN_DATA_W  = ((SID_W + HASH_W + 7) / 8) * 8;
    localparam int OUT_BITS   = CNT_W + SID_W + IDX_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_ROUTE  = 2'd2;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_EMPTY      = 2'd1;
    localparam logic [1:0] STAT_FULL       = 2'd2;
    localparam logic [1:0] STAT_NO_PARTNER = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_REQ,
        ST_SCAN_CMP,
        ST_LOOK_REQ,
        ST_LOOK_DATA,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } t_state;

endpackage

// ===== src/chrr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrr_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module chrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/consistent_hash_ring_router_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_router_top: sorted hash ring of servers
// add, remove and route over a ring of server entries kept in one ram
// ----------------------------------------------------------------------------
// The ring lives in a single ram (hash and server id per entry) and is
// walked by one comparator under a small sequencer around the ram's one
// read port and one write port. A lookup reads one entry at a time from
// slot 0 up to the first hash at least the key hash. Route then reads the
// owner of the matched slot. Add moves every entry at and above the
// insertion slot up by one, remove moves every entry above the removed
// slot down by one. Full-ring add, empty-ring remove or route and unused
// opcodes skip the scan and go straight to the finish state. The input is
// ready only while the sequencer is idle; a finished result waits in the
// output register, so the next item is taken while the previous result
// is still pending.
// ----------------------------------------------------------------------------
module consistent_hash_ring_router_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [15:0] srv_id, [47:16] key_hash
    input  logic [chrr_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                      i_s_axis_tuser,
    // result items
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [6:0] slot, [22:7] owner_id, [28:23] partner_slot, zero above
    output logic [chrr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]                      o_m_axis_tuser
);

    localparam int CW = chrr_pkg::CNT_W;
    localparam int IW = chrr_pkg::IDX_W;
    localparam int HW = chrr_pkg::HASH_W;
    localparam int SW = chrr_pkg::SID_W;
    localparam int EW = chrr_pkg::ENTRY_W;

    // sequencer state and item context
    chrr_pkg::t_state r_state, n_state;
    logic [1:0]       r_op, n_op;
    logic [SW-1:0]    r_sid, n_sid;
    logic [HW-1:0]    r_hash, n_hash;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;

    // result being built
    logic [CW-1:0]    r_slot, n_slot;
    logic [SW-1:0]    r_owner, n_owner;
    logic [IW-1:0]    r_partner, n_partner;
    logic [1:0]       r_status, n_status;

    // output register
    logic             r_out_valid, n_out_valid;
    logic [CW-1:0]    r_out_slot, n_out_slot;
    logic [SW-1:0]    r_out_owner, n_out_owner;
    logic [IW-1:0]    r_out_partner, n_out_partner;
    logic [1:0]       r_out_status, n_out_status;

    // ram port
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [IW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;
    logic [HW-1:0]    rd_hash;
    logic [SW-1:0]    rd_sid;

    // shared lookup unit
    logic             key_le;
    logic             scan_done;
    logic [CW-1:0]    scan_slot;
    logic [CW-1:0]    wrap_slot;
    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    idx_dec;
    logic             s_fire;
    logic             out_free;

    chrr_ram #(
        .WIDTH (EW),
        .DEPTH (chrr_pkg::RING_SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // entry layout: hash low, server id high
    assign rd_hash = ram_rdata[HW-1:0];
    assign rd_sid  = ram_rdata[EW-1:HW];

    assign key_le   = (r_hash <= rd_hash);
    assign idx_inc  = r_idx + CW'(1);
    assign idx_dec  = r_idx - CW'(1);
    assign s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // scan ends when the count is reached or a hash at least the key is seen
    always_comb begin
        scan_done = 1'b0;
        scan_slot = r_idx;
        if (r_state == chrr_pkg::ST_SCAN_REQ && r_idx == r_count) begin
            scan_done = 1'b1;
        end else if (r_state == chrr_pkg::ST_SCAN_CMP && key_le) begin
            scan_done = 1'b1;
        end
        // no match wraps to slot 0 for remove and route
        wrap_slot = (scan_slot == r_count) ? '0 : scan_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chrr_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_sid         <= n_sid;
        r_hash        <= n_hash;
        r_idx         <= n_idx;
        r_slot        <= n_slot;
        r_owner       <= n_owner;
        r_partner     <= n_partner;
        r_status      <= n_status;
        r_out_slot    <= n_out_slot;
        r_out_owner   <= n_out_owner;
        r_out_partner <= n_out_partner;
        r_out_status  <= n_out_status;
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_sid         = r_sid;
        n_hash        = r_hash;
        n_count       = r_count;
        n_idx         = r_idx;
        n_slot        = r_slot;
        n_owner       = r_owner;
        n_partner     = r_partner;
        n_status      = r_status;
        n_out_valid   = r_out_valid;
        n_out_slot    = r_out_slot;
        n_out_owner   = r_out_owner;
        n_out_partner = r_out_partner;
        n_out_status  = r_out_status;
        ram_we        = 1'b0;
        ram_waddr     = r_idx[IW-1:0];
        ram_wdata     = ram_rdata;
        ram_raddr     = r_idx[IW-1:0];
        o_s_axis_tready = 1'b0;

        // result leaves when the consumer takes it
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            chrr_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (s_fire) begin
                    n_op      = i_s_axis_tuser;
                    n_sid     = i_s_axis_tdata[SW-1:0];
                    n_hash    = i_s_axis_tdata[SW+HW-1:SW];
                    n_idx     = '0;
                    n_slot    = '0;
                    n_owner   = '0;
                    n_partner = '0;
                    n_status  = chrr_pkg::STAT_OK;
                    n_state   = chrr_pkg::ST_FINISH;
                    if (i_s_axis_tuser == chrr_pkg::OP_ADD) begin
                        if (r_count == CW'(chrr_pkg::RING_SLOTS)) begin
                            n_status = chrr_pkg::STAT_FULL;
                        end else begin
                            n_state = chrr_pkg::ST_SCAN_REQ;
                        end
                    end else if (i_s_axis_tuser == chrr_pkg::OP_REMOVE ||
                                 i_s_axis_tuser == chrr_pkg::OP_ROUTE) begin
                        if (r_count == '0) begin
                            n_status = chrr_pkg::STAT_EMPTY;
                        end else begin
                            n_state = chrr_pkg::ST_SCAN_REQ;
                        end
                    end
                end
            end

            chrr_pkg::ST_SCAN_REQ: begin
                if (!scan_done) begin
                    n_state = chrr_pkg::ST_SCAN_CMP;
                end
            end

            chrr_pkg::ST_SCAN_CMP: begin
                if (!scan_done) begin
                    n_idx   = idx_inc;
                    n_state = chrr_pkg::ST_SCAN_REQ;
                end
            end

            chrr_pkg::ST_LOOK_REQ: begin
                ram_raddr = r_slot[IW-1:0];
                n_state   = chrr_pkg::ST_LOOK_DATA;
            end

            chrr_pkg::ST_LOOK_DATA: begin
                n_owner = rd_sid;
                n_state = chrr_pkg::ST_FINISH;
            end

            chrr_pkg::ST_SHIFT_RD: begin
                if (r_op == chrr_pkg::OP_ADD) begin
                    if (r_idx == r_slot) begin
                        // hole is open, drop the new entry in
                        ram_we    = 1'b1;
                        ram_waddr = r_slot[IW-1:0];
                        ram_wdata = {r_sid, r_hash};
                        n_count   = r_count + CW'(1);
                        n_state   = chrr_pkg::ST_FINISH;
                    end else begin
                        ram_raddr = idx_dec[IW-1:0];
                        n_state   = chrr_pkg::ST_SHIFT_WR;
                    end
                end else begin
                    if (idx_inc >= r_count) begin
                        n_count = r_count - CW'(1);
                        n_state = chrr_pkg::ST_FINISH;
                    end else begin
                        ram_raddr = idx_inc[IW-1:0];
                        n_state   = chrr_pkg::ST_SHIFT_WR;
                    end
                end
            end

            chrr_pkg::ST_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[IW-1:0];
                ram_wdata = ram_rdata;
                n_idx     = (r_op == chrr_pkg::OP_ADD) ? idx_dec : idx_inc;
                n_state   = chrr_pkg::ST_SHIFT_RD;
            end

            chrr_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_slot    = r_slot;
                    n_out_owner   = r_owner;
                    n_out_partner = r_partner;
                    n_out_status  = r_status;
                    n_state       = chrr_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = chrr_pkg::ST_IDLE;
            end
        endcase

        // end of lookup: set slot, for add and remove also partner or status, pick the next phase
        if (scan_done) begin
            if (r_op == chrr_pkg::OP_ADD) begin
                n_slot  = scan_slot;
                n_idx   = r_count;
                n_state = chrr_pkg::ST_SHIFT_RD;
                if (r_count == '0) begin
                    n_status = chrr_pkg::STAT_NO_PARTNER;
                end else begin
                    n_partner = wrap_slot[IW-1:0];
                end
            end else if (r_op == chrr_pkg::OP_REMOVE) begin
                n_slot  = wrap_slot;
                n_idx   = wrap_slot;
                n_state = chrr_pkg::ST_SHIFT_RD;
                if (r_count == CW'(1)) begin
                    n_status = chrr_pkg::STAT_NO_PARTNER;
                end else if (wrap_slot + CW'(1) == r_count) begin
                    n_partner = '0;
                end else begin
                    n_partner = IW'(wrap_slot + CW'(1));
                end
            end else begin
                n_slot  = wrap_slot;
                n_state = chrr_pkg::ST_LOOK_REQ;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(chrr_pkg::OUT_DATA_W - chrr_pkg::OUT_BITS){1'b0}},
                              r_out_partner, r_out_owner, r_out_slot};
    assign o_m_axis_tuser  = r_out_status;

`ifndef SYNTH
    // the ring never holds more entries than it has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(chrr_pkg::RING_SLOTS))
        else $error("ring count above slot count");

    // an accepted item always starts the sequencer
    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_state != chrr_pkg::ST_IDLE)
        else $error("accepted item left sequencer idle");

    // the ring is written only while entries are moved or inserted
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == chrr_pkg::ST_SHIFT_RD || r_state == chrr_pkg::ST_SHIFT_WR))
        else $error("ring write outside shift phase");

    // the count changes only when a shift pass completes
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            ($past(r_state) == chrr_pkg::ST_SHIFT_RD && r_state == chrr_pkg::ST_FINISH))
        else $error("ring count changed outside shift completion");
`endif

endmodule
